FILE: design/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Types, widths, codes and the arctangent table for the tilt angle pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package atl_pkg;

    localparam int AXIS_W     = 16;
    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = 3 * AXIS_W;
    localparam int TILT_W     = 17;
    localparam int OUT_DATA_W = 24;

    // sum of two squares and its root (radicand is the sum with 16 zero bits below)
    localparam int SUM_W = 2 * AXIS_W;
    localparam int MAG_W = 24;
    localparam int REM_W = MAG_W + 3;

    // vector and angle datapath
    localparam int AXIS_SCALE_SH = 8;
    localparam int CXY_W         = 27;
    localparam int ACC_FRAC      = 20;
    localparam int ZW            = 30;
    localparam int TABLE_LEN     = 24;

    localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * (2 ** ACC_FRAC));
    localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * (2 ** ACC_FRAC));

    typedef enum logic [MODE_W-1:0] {
        MODE_Y_TILT    = 2'd0,
        MODE_FROM_VERT = 2'd1,
        MODE_X_TILT    = 2'd2,
        MODE_INVALID   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [AXIS_W-1:0] axis;
    } atl_side_t;

    // atan(2^-i) in degrees, 20 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        case (idx)
            0:       return ZW'(47185920);
            1:       return ZW'(27855475);
            2:       return ZW'(14718068);
            3:       return ZW'(7471121);
            4:       return ZW'(3750058);
            5:       return ZW'(1876857);
            6:       return ZW'(938658);
            7:       return ZW'(469357);
            8:       return ZW'(234682);
            9:       return ZW'(117342);
            10:      return ZW'(58671);
            11:      return ZW'(29335);
            12:      return ZW'(14668);
            13:      return ZW'(7334);
            14:      return ZW'(3667);
            15:      return ZW'(1833);
            16:      return ZW'(917);
            17:      return ZW'(458);
            18:      return ZW'(229);
            19:      return ZW'(115);
            20:      return ZW'(57);
            21:      return ZW'(29);
            22:      return ZW'(14);
            23:      return ZW'(7);
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: design/atl_mag.sv
// ----------------------------------------------------------------------------
// atl_mag
// Axis selection, squares, sum and a pipelined digit-by-digit square root
// ----------------------------------------------------------------------------
`default_nettype none

module atl_mag
    import atl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  mode_t                    mode,
    input  logic signed [AXIS_W-1:0] accel_x,
    input  logic signed [AXIS_W-1:0] accel_y,
    input  logic signed [AXIS_W-1:0] accel_z,
    output logic                     out_valid,
    output atl_side_t                out_side,
    output logic [MAG_W-1:0]         out_mag
);

    atl_side_t                  sel_side;
    logic signed [AXIS_W-1:0]   sel_a;
    logic signed [AXIS_W-1:0]   sel_b;
    logic signed [SUM_W-1:0]    prod_a;
    logic signed [SUM_W-1:0]    prod_b;

    logic                       sq_valid_reg;
    atl_side_t                  sq_side_reg;
    logic [SUM_W-1:0]           sq_a_reg;
    logic [SUM_W-1:0]           sq_b_reg;

    logic                       v_reg    [0:MAG_W];
    atl_side_t                  side_reg [0:MAG_W];
    logic [SUM_W-1:0]           rad_reg  [0:MAG_W];
    logic [REM_W-1:0]           rem_reg  [0:MAG_W];
    logic [MAG_W-1:0]           root_reg [0:MAG_W];

    always_comb
    begin
        sel_side.mode = mode;
        case (mode)
            MODE_Y_TILT:
            begin
                sel_side.axis = accel_y;
                sel_a         = accel_x;
                sel_b         = accel_z;
            end
            MODE_FROM_VERT:
            begin
                sel_side.axis = accel_z;
                sel_a         = accel_x;
                sel_b         = accel_y;
            end
            MODE_X_TILT:
            begin
                sel_side.axis = accel_x;
                sel_a         = accel_y;
                sel_b         = accel_z;
            end
            default:
            begin
                sel_side.axis = '0;
                sel_a         = '0;
                sel_b         = '0;
            end
        endcase
    end

    assign prod_a = sel_a * sel_a;
    assign prod_b = sel_b * sel_b;

    // squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg <= sel_side;
            sq_a_reg    <= $unsigned(prod_a);
            sq_b_reg    <= $unsigned(prod_b);
        end
    end

    // sum of squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= sq_side_reg;
            rad_reg[0]  <= sq_a_reg + sq_b_reg;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < MAG_W; k++)
    begin : g_root
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        logic             take;

        assign shifted = {rem_reg[k][REM_W-3:0], rad_reg[k][SUM_W-1 -: 2]};
        assign trial   = {1'b0, root_reg[k], 2'b01};
        assign take    = (shifted >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                rad_reg[k+1]  <= {rad_reg[k][SUM_W-3:0], 2'b00};
                rem_reg[k+1]  <= take ? (shifted - trial) : shifted;
                root_reg[k+1] <= {root_reg[k][MAG_W-2:0], take};
            end
        end
    end

    assign out_valid = v_reg[MAG_W];
    assign out_side  = side_reg[MAG_W];
    assign out_mag   = root_reg[MAG_W];

endmodule

`default_nettype wire

FILE: design/atl_cordic.sv
// ----------------------------------------------------------------------------
// atl_cordic
// Quadrant handling, pipelined vectoring CORDIC, rounding and range clamp
// ----------------------------------------------------------------------------
`default_nettype none

module atl_cordic
    import atl_pkg::*;
#(
    parameter int NUM_ITER        = 16,
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  atl_side_t         in_side,
    input  logic [MAG_W-1:0]  in_mag,
    output logic              out_valid,
    output logic [TILT_W-1:0] out_tilt
);

    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF   = ZW'(2 ** (SH - 1));
    localparam logic signed [ZW-1:0] LIM90  = ZW'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [ZW-1:0] LIM180 = ZW'(180 * (2 ** ANGLE_FRAC_BITS));

    logic signed [CXY_W-1:0] opnd;
    logic signed [CXY_W-1:0] mag_s;
    logic signed [CXY_W-1:0] num;
    logic signed [CXY_W-1:0] den;
    logic signed [CXY_W-1:0] x0;
    logic signed [CXY_W-1:0] y0;
    logic signed [ZW-1:0]    z0;
    logic                    hold0;

    logic                    v_reg    [0:NUM_ITER];
    logic                    vert_reg [0:NUM_ITER];
    logic                    hold_reg [0:NUM_ITER];
    logic signed [CXY_W-1:0] x_reg    [0:NUM_ITER];
    logic signed [CXY_W-1:0] y_reg    [0:NUM_ITER];
    logic signed [ZW-1:0]    z_reg    [0:NUM_ITER];

    logic signed [ZW-1:0]    rounded;
    logic signed [ZW-1:0]    lo;
    logic signed [ZW-1:0]    hi;
    logic signed [ZW-1:0]    clamped;

    assign opnd  = CXY_W'(in_side.axis) <<< AXIS_SCALE_SH;
    assign mag_s = $signed(CXY_W'(in_mag));
    assign num   = (in_side.mode == MODE_FROM_VERT) ? mag_s : opnd;
    assign den   = (in_side.mode == MODE_FROM_VERT) ? opnd : mag_s;

    // exact answers on the axes, quarter turn when the vector points left
    always_comb
    begin
        x0    = den;
        y0    = num;
        z0    = '0;
        hold0 = 1'b0;
        if (in_side.mode == MODE_INVALID)
        begin
            hold0 = 1'b1;
        end
        else if (num == '0)
        begin
            hold0 = 1'b1;
            z0    = (den < 0) ? DEG180 : '0;
        end
        else if (den == '0)
        begin
            hold0 = 1'b1;
            z0    = (num > 0) ? DEG90 : -DEG90;
        end
        else if (den < 0)
        begin
            if (num >= 0)
            begin
                x0 = num;
                y0 = -den;
                z0 = DEG90;
            end
            else
            begin
                x0 = -num;
                y0 = den;
                z0 = -DEG90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vert_reg[0] <= (in_side.mode == MODE_FROM_VERT);
            hold_reg[0] <= hold0;
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
        end
    end

    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_iter
        logic signed [CXY_W-1:0] dx;
        logic signed [CXY_W-1:0] dy;
        logic                    up;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign up = (y_reg[i] >= 0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vert_reg[i+1] <= vert_reg[i];
                hold_reg[i+1] <= hold_reg[i];
                x_reg[i+1]    <= up ? (x_reg[i] + dx) : (x_reg[i] - dx);
                y_reg[i+1]    <= up ? (y_reg[i] - dy) : (y_reg[i] + dy);
                if (hold_reg[i])
                begin
                    z_reg[i+1] <= z_reg[i];
                end
                else
                begin
                    z_reg[i+1] <= up ? (z_reg[i] + atan_deg(i)) : (z_reg[i] - atan_deg(i));
                end
            end
        end
    end

    // round half up, then clamp to the selector's range
    always_comb
    begin
        rounded = (z_reg[NUM_ITER] + HALF) >>> SH;
        lo      = vert_reg[NUM_ITER] ? '0 : -LIM90;
        hi      = vert_reg[NUM_ITER] ? LIM180 : LIM90;
        if (rounded < lo)
        begin
            clamped = lo;
        end
        else if (rounded > hi)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = rounded;
        end
    end

    assign out_valid = v_reg[NUM_ITER];
    assign out_tilt  = clamped[TILT_W-1:0];

endmodule

`default_nettype wire

FILE: design/accel_tilt_angle.sv
// ----------------------------------------------------------------------------
// accel_tilt_angle
// Tilt angle in degrees from one three-axis accelerometer sample
// Pipeline: squares and sum, 24 root stages, the quadrant stage, one CORDIC
// stage per step (CORDIC_STAGES, at most 24) and the output register.
// Throughput: one sample per cycle; a stalled output parks one result in a
// skid register and holds the pipeline until it drains.
// Reset: asynchronous, clears the valid bits and the output handshake only.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angle
    import atl_pkg::*;
#(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // accel_x, accel_y, accel_z
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // tilt_degrees, zero padding
);

    localparam int NUM_ITER = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic              en;
    logic              mag_valid;
    atl_side_t         mag_side;
    logic [MAG_W-1:0]  mag;
    logic              res_valid;
    logic [TILT_W-1:0] res_tilt;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TILT_W-1:0] out_data_reg;
    logic [TILT_W-1:0] out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [TILT_W-1:0] skid_data_reg;
    logic [TILT_W-1:0] skid_data_next;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    atl_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .mode      (mode_t'(s_axis_tuser)),
        .accel_x   ($signed(s_axis_tdata[AXIS_W-1:0])),
        .accel_y   ($signed(s_axis_tdata[2*AXIS_W-1:AXIS_W])),
        .accel_z   ($signed(s_axis_tdata[3*AXIS_W-1:2*AXIS_W])),
        .out_valid (mag_valid),
        .out_side  (mag_side),
        .out_mag   (mag)
    );

    atl_cordic #(
        .NUM_ITER        (NUM_ITER),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mag_valid),
        .in_side   (mag_side),
        .in_mag    (mag),
        .out_valid (res_valid),
        .out_tilt  (res_tilt)
    );

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_tilt;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_tilt;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - TILT_W){1'b0}}, out_data_reg};

`ifndef SYNTH
    // a parked result always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // input side only stalls after a refused output transfer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    // an empty output never holds back the input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output is empty");
`endif

endmodule

`default_nettype wire
